// ===== rtl/packet_slot_fifo_macros.svh =====
// ----------------------------------------------------------------------------
// Packet slot FIFO assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_SLOT_FIFO_MACROS_SVH
`define PACKET_SLOT_FIFO_MACROS_SVH

// Same-cycle implication.
`define PSF_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// psf_pkg
// Command, status and word types shared by the packet slot FIFO modules.
// ----------------------------------------------------------------------------
package psf_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE_BYTE = 3'd0,
    CMD_COMMIT     = 3'd1,
    CMD_READ_BYTE  = 3'd2,
    CMD_RELEASE    = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  localparam int unsigned LenW = 9;

  typedef struct packed {
    logic [2:0]      command;
    logic [7:0]      byte_offset;
    logic [7:0]      write_data;
    logic [LenW-1:0] packet_length;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [7:0]      read_data;
    logic [LenW-1:0] read_length;
    logic            full_flag;
    logic            empty_flag;
  } out_word_t;

  // Per-command memory requests and result flags from the pointer control.
  typedef struct packed {
    logic    byte_we;
    logic    byte_re;
    logic    len_we;
    logic    len_fwd;
    logic    len_valid;
    status_e status;
    logic    full;
    logic    empty;
  } mem_req_t;

endpackage

// ===== rtl/psf_ptr_ctrl.sv =====
// ----------------------------------------------------------------------------
// psf_ptr_ctrl
// Write/read pointers with wrap bit, length fill count, command decode.
// ----------------------------------------------------------------------------
`include "packet_slot_fifo_macros.svh"

module psf_ptr_ctrl #(
  parameter int SLOTS      = 16,
  parameter int SLOT_BYTES = 256,
  parameter int SIW        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  psf_pkg::in_word_t   cmd_i,
  input  logic [8:0]          cfg_cap_i,
  output psf_pkg::mem_req_t   req_o,
  output logic [SIW-1:0]      wslot_o,
  output logic [SIW-1:0]      rslot_o,
  output logic [SIW-1:0]      len_rd_slot_o
);
  import psf_pkg::*;

  localparam int PW = (2 * SLOTS > 1) ? $clog2(2 * SLOTS) : 1;
  localparam int FW = $clog2(SLOTS + 1);

  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [SIW-1:0] wslot, rslot, rslot_nxt, wslot_nxt;
  logic          empty_now, full_now, too_long;

  function automatic logic [SIW-1:0] slot_of(logic [PW-1:0] ptr);
    return (ptr >= PW'(SLOTS)) ? SIW'(ptr - PW'(SLOTS)) : SIW'(ptr);
  endfunction

  function automatic logic [PW-1:0] advance(logic [PW-1:0] ptr);
    return (ptr == PW'(2 * SLOTS - 1)) ? '0 : ptr + PW'(1);
  endfunction

  assign wslot     = slot_of(wptr_q);
  assign rslot     = slot_of(rptr_q);
  assign empty_now = (wptr_q == rptr_q);
  assign full_now  = (wslot == rslot) && !empty_now;
  assign too_long  = (cmd_i.packet_length > cfg_cap_i) ||
                     (int'(cmd_i.packet_length) > SLOT_BYTES);

  // Next pointers, memory requests and post-command flags
  always_comb begin
    wptr_d         = wptr_q;
    rptr_d         = rptr_q;
    req_o.byte_we  = 1'b0;
    req_o.byte_re  = 1'b0;
    req_o.len_we   = 1'b0;
    req_o.status   = ST_OK;
    if (accept_i) begin
      case (cmd_i.command)
        CMD_WRITE_BYTE: begin
          if (full_now) req_o.status = ST_FULL;
          else          req_o.byte_we = 1'b1;
        end
        CMD_COMMIT: begin
          if (too_long) begin
            req_o.status = ST_TOO_LONG;
          end else if (full_now) begin
            req_o.status = ST_FULL;
          end else begin
            req_o.len_we = 1'b1;
            wptr_d       = advance(wptr_q);
          end
        end
        CMD_READ_BYTE: begin
          // stale data is still returned when empty
          req_o.byte_re = 1'b1;
          if (empty_now) req_o.status = ST_EMPTY;
        end
        CMD_RELEASE: begin
          if (empty_now) req_o.status = ST_EMPTY;
          else           rptr_d = advance(rptr_q);
        end
        CMD_CLEAR: begin
          wptr_d = '0;
          rptr_d = '0;
        end
        default: ;
      endcase
    end

    // Length entries are written in slot order from zero, so the written set
    // is always a prefix: a fill count stands in for per-entry valid bits.
    wslot_nxt       = slot_of(wptr_d);
    rslot_nxt       = slot_of(rptr_d);
    req_o.empty     = (wptr_d == rptr_d);
    req_o.full      = (wslot_nxt == rslot_nxt) && (wptr_d != rptr_d);
    req_o.len_fwd   = req_o.len_we && (wslot == rslot_nxt);
    req_o.len_valid = (FW'(rslot_nxt) < fill_q);
    fill_d          = fill_q;
    if (req_o.len_we && (FW'(wslot) == fill_q)) fill_d = fill_q + FW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  assign wslot_o       = wslot;
  assign rslot_o       = rslot;
  assign len_rd_slot_o = rslot_nxt;

  `PSF_ASSERT(a_fill_range, 1'b1, fill_q <= FW'(SLOTS), "length fill count past depth")
  `PSF_ASSERT(a_ptr_range, 1'b1, (int'(wptr_q) < 2*SLOTS) && (int'(rptr_q) < 2*SLOTS), "bad ptr")
  `PSF_ASSERT_NXT(a_clear_empty, accept_i && (cmd_i.command == CMD_CLEAR), (wptr_q == '0) && (rptr_q == '0), "clear left pointers set")

endmodule

// ===== rtl/packet_slot_fifo.sv =====
// ----------------------------------------------------------------------------
// packet_slot_fifo
// FIFO of fixed-size byte slots with a stored packet length per slot.
// ----------------------------------------------------------------------------
// Takes one command per clock: a command is taken on any edge with start
// high (busy never rises, there is no clearing pass after reset). Every
// command gives exactly one result word, shown on res_o with res_valid_o
// high for one cycle, the cycle right after the command was taken; the
// receiver cannot stall it. The result comes from the registered read of the
// byte and length memories. Commands: write_byte stores a byte at an
// offset (taken modulo SLOT_BYTES) of the slot at the write pointer;
// commit records a length and advances the write pointer; read_byte
// returns a byte of the slot at the read pointer; release advances the
// read pointer; clear empties the FIFO but keeps memory contents. Every
// result carries the length of the slot at the read pointer after the
// command and the full/empty flags. Bytes never written read back as
// don't-care. The capacity register (cfg_we_i/cfg_wdata_i) limits commit
// lengths; write it only while no command is in flight.
// ----------------------------------------------------------------------------
`include "packet_slot_fifo_macros.svh"

module packet_slot_fifo #(
  parameter int SLOTS      = 16,
  parameter int SLOT_BYTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  psf_pkg::in_word_t   cmd_i,
  input  logic                cfg_we_i,
  input  logic [8:0]          cfg_wdata_i,
  output logic                res_valid_o,
  output psf_pkg::out_word_t  res_o
);
  import psf_pkg::*;

  localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BYTES = SLOTS * SLOT_BYTES;
  localparam int AW    = (BYTES > 1) ? $clog2(BYTES) : 1;
  localparam int OFFW  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int TABW  = $clog2(256 * OFFW);
  localparam int CAP_RST = (SLOT_BYTES > 511) ? 511 : SLOT_BYTES;

  // byte_offset modulo SLOT_BYTES, one entry per 8-bit offset
  function automatic logic [256*OFFW-1:0] build_mod_tab();
    logic [256*OFFW-1:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) t[i*OFFW +: OFFW] = OFFW'(i % SLOT_BYTES);
    return t;
  endfunction

  localparam logic [256*OFFW-1:0] ModTab = build_mod_tab();

  logic           accept;
  logic [8:0]     cap_q;
  mem_req_t       req;
  logic [SIW-1:0] wslot, rslot, len_rd_slot, byte_slot;
  logic [OFFW-1:0] off;
  logic [AW-1:0]  byte_addr;

  // memories
  logic [7:0]      byte_mem [BYTES];
  logic [LenW-1:0] len_mem  [SLOTS];
  logic [7:0]      byte_rd_q;
  logic [LenW-1:0] len_rd_q;

  // result stage
  logic            valid_q;
  status_e         status_q;
  logic            full_q, empty_q, rd_sel_q, fwd_q, len_valid_q;
  logic [LenW-1:0] fwd_len_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 9'(CAP_RST);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  psf_ptr_ctrl #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES),
    .SIW        (SIW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .cmd_i         (cmd_i),
    .cfg_cap_i     (cap_q),
    .req_o         (req),
    .wslot_o       (wslot),
    .rslot_o       (rslot),
    .len_rd_slot_o (len_rd_slot)
  );

  // Byte address: writes go to the write slot, reads to the read slot.
  assign byte_slot = req.byte_we ? wslot : rslot;
  assign off       = ModTab[TABW'(cmd_i.byte_offset) * TABW'(OFFW) +: OFFW];
  assign byte_addr = AW'(AW'(byte_slot) * AW'(SLOT_BYTES)) + AW'(off);

  // One access per command, so the byte store is single ported.
  always_ff @(posedge clk_i) begin
    if (req.byte_we) byte_mem[byte_addr] <= cmd_i.write_data;
    if (req.byte_re) byte_rd_q <= byte_mem[byte_addr];
  end

  // Length store: write at the write slot, read at the post-command read
  // slot. A commit into the slot being read is forwarded around the RAM.
  always_ff @(posedge clk_i) begin
    if (req.len_we) len_mem[wslot] <= cmd_i.packet_length;
    if (accept)     len_rd_q <= len_mem[len_rd_slot];
    if (accept)     fwd_len_q <= cmd_i.packet_length;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      status_q    <= ST_OK;
      full_q      <= 1'b0;
      empty_q     <= 1'b1;
      rd_sel_q    <= 1'b0;
      fwd_q       <= 1'b0;
      len_valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        status_q    <= req.status;
        full_q      <= req.full;
        empty_q     <= req.empty;
        rd_sel_q    <= req.byte_re;
        fwd_q       <= req.len_fwd;
        len_valid_q <= req.len_valid;
      end
    end
  end

  always_comb begin
    res_o.status      = status_q;
    res_o.read_data   = rd_sel_q ? byte_rd_q : 8'd0;
    res_o.read_length = fwd_q ? fwd_len_q : (len_valid_q ? len_rd_q : '0);
    res_o.full_flag   = full_q;
    res_o.empty_flag  = empty_q;
  end

  assign res_valid_o = valid_q;

  `PSF_ASSERT_NXT(a_result_follows, accept, res_valid_o, "taken command gave no result")
  `PSF_ASSERT_NXT(a_no_spurious, !accept, !res_valid_o, "result without a command")
  `PSF_ASSERT(a_flags_excl, res_valid_o, !(res_o.full_flag && res_o.empty_flag), "full and empty together")

endmodule

// ===== sim/packet_slot_fifo_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_slot_fifo_tb
// Self-checking bench for the packet slot FIFO. A directed pass drives edge
// cases and then random producer/consumer traffic runs under three settings
// of the slot capacity. A local mirror of the FIFO predicts every result
// word, and a monitor compares each result against it field by field.
// ----------------------------------------------------------------------------
module packet_slot_fifo_tb;
  import psf_pkg::*;

  localparam int SLOTS       = 16;
  localparam int SLOT_BYTES  = 256;
  localparam int STALL_LIMIT = 1000;   // cycles with no word moving either way
  localparam int RANDOM_WORDS = 173;   // per random phase, three phases

  // Codes 5..7 are unassigned; the FIFO must treat them as no-ops.
  localparam logic [2:0] CMD_SPARE_BASE = 3'd5;
  localparam int         CMD_SPARE_COUNT = 3;

  // Bench clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // DUT connections; the inputs are driven to known values from time zero.
  logic       start       = 1'b0;
  logic       busy;
  in_word_t   cmd_i       = '0;
  logic       cfg_we_i    = 1'b0;
  logic [8:0] cfg_wdata_i = '0;
  logic       res_valid_o;
  out_word_t  res_o;

  packet_slot_fifo #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // --------------------------------------------------------------------------
  // Mirror of the FIFO state. Pointers carry the wrap bit in bit 4.
  // --------------------------------------------------------------------------
  logic [7:0] mirror_bytes [SLOTS*SLOT_BYTES];
  bit         byte_written [SLOTS*SLOT_BYTES];  // guards reads of unwritten bytes
  logic [8:0] mirror_lens  [SLOTS] = '{default: '0};
  logic [4:0] wr_ptr       = '0;
  logic [4:0] rd_ptr       = '0;
  logic       mirror_full  = 1'b0;
  logic       mirror_empty = 1'b1;
  logic [8:0] capacity_reg = 9'd256;

  out_word_t  awaited_results [$];   // predicted result words, oldest first
  int         mismatches     = 0;
  int         sender_idle_pct = 19;
  bit         producer_ahead  = 1'b1;  // random traffic leans to fill vs. drain
  int         cmd_tally    [8];
  int         status_tally [4];
  string      capacity_log = "256";

  // Applies one command to the mirror and returns the result word it gives.
  function automatic out_word_t predict_fifo_result(input in_word_t w);
    out_word_t  r;
    logic [8:0] cap_eff;
    r = '0;
    r.status = ST_OK;
    cap_eff = (capacity_reg > SLOT_BYTES) ? 9'(SLOT_BYTES) : capacity_reg;
    case (w.command)
      CMD_WRITE_BYTE: begin
        if (mirror_full) begin
          r.status = ST_FULL;
        end else begin
          mirror_bytes[{wr_ptr[3:0], w.byte_offset}] = w.write_data;
          byte_written[{wr_ptr[3:0], w.byte_offset}] = 1'b1;
        end
      end
      CMD_COMMIT: begin
        // Length check wins over the full check.
        if (w.packet_length > cap_eff) begin
          r.status = ST_TOO_LONG;
        end else if (mirror_full) begin
          r.status = ST_FULL;
        end else begin
          mirror_lens[wr_ptr[3:0]] = w.packet_length;
          wr_ptr = wr_ptr + 5'd1;
        end
      end
      CMD_READ_BYTE: begin
        // Stale data still comes back when empty.
        if (mirror_empty) r.status = ST_EMPTY;
        r.read_data = mirror_bytes[{rd_ptr[3:0], w.byte_offset}];
      end
      CMD_RELEASE: begin
        if (mirror_empty) r.status = ST_EMPTY;
        else rd_ptr = rd_ptr + 5'd1;
      end
      CMD_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
      end
      default: ;
    endcase
    mirror_empty  = (wr_ptr == rd_ptr);
    mirror_full   = (wr_ptr[3:0] == rd_ptr[3:0]) && !mirror_empty;
    r.read_length = mirror_lens[rd_ptr[3:0]];
    r.full_flag   = mirror_full;
    r.empty_flag  = mirror_empty;
    return r;
  endfunction

  function automatic in_word_t compose_word(input logic [2:0] command,
                                            input logic [7:0] offset,
                                            input logic [7:0] data,
                                            input logic [8:0] length);
    in_word_t w;
    w.command       = command;
    w.byte_offset   = offset;
    w.write_data    = data;
    w.packet_length = length;
    return w;
  endfunction

  // Finds a byte already written in a slot, starting at a random offset.
  function automatic bit find_written_offset(input logic [3:0] slot,
                                             output logic [7:0] offset);
    logic [7:0] probe;
    probe  = 8'($urandom_range(0, 255));
    offset = '0;
    for (int i = 0; i < SLOT_BYTES; i++) begin
      if (byte_written[{slot, probe}]) begin
        offset = probe;
        return 1'b1;
      end
      probe = probe + 8'd1;
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Driving. Idle gaps go in before the word; start stays high back to back.
  // The mirror is stepped at the accepting edge, so the next word is built
  // from up-to-date state.
  // --------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    awaited_results.push_back(predict_fifo_result(w));
    cmd_tally[w.command]++;
  endtask

  // Stop sending and wait for every predicted word to come back.
  task automatic drain_results();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);  // margin after the last result word
  endtask

  // Only called once drained, so no command is in flight.
  task automatic write_capacity(input logic [8:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    capacity_reg  = value;
    capacity_log  = {capacity_log, $sformatf(",%0d", value)};
  endtask

  // Random producer/consumer word. Read offsets always hit written bytes.
  task automatic pick_random_word(output in_word_t w);
    int unsigned roll;
    int unsigned t_write, t_commit, t_read, t_release, t_clear;
    logic [8:0]  cap_eff;
    logic [7:0]  hit;
    cap_eff = (capacity_reg > SLOT_BYTES) ? 9'(SLOT_BYTES) : capacity_reg;

    // Swing between filling and draining so both full and empty get hit,
    // lingering a little at each end to poke the rejects.
    if (mirror_full && $urandom_range(0, 3) == 0) producer_ahead = 1'b0;
    else if (mirror_empty && $urandom_range(0, 3) == 0) producer_ahead = 1'b1;
    else if ($urandom_range(0, 59) == 0) producer_ahead = !producer_ahead;

    if (producer_ahead) begin
      t_write = 40; t_commit = 65; t_read = 85; t_release = 95; t_clear = 97;
    end else begin
      t_write = 25; t_commit = 33; t_read = 63; t_release = 95; t_clear = 97;
    end

    w.byte_offset   = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                           : 8'($urandom_range(0, 255));
    w.write_data    = 8'($urandom);
    w.packet_length = 9'($urandom_range(0, SLOT_BYTES));

    roll = $urandom_range(0, 99);
    if (roll < t_write)        w.command = CMD_WRITE_BYTE;
    else if (roll < t_commit)  w.command = CMD_COMMIT;
    else if (roll < t_read)    w.command = CMD_READ_BYTE;
    else if (roll < t_release) w.command = CMD_RELEASE;
    else if (roll < t_clear)   w.command = CMD_CLEAR;
    else w.command = CMD_SPARE_BASE + 3'($urandom_range(0, CMD_SPARE_COUNT - 1));

    if (w.command == CMD_READ_BYTE) begin
      if (find_written_offset(rd_ptr[3:0], hit)) w.byte_offset = hit;
      else w.command = CMD_WRITE_BYTE;  // nothing readable in this slot yet
    end
    // Mostly legal lengths; the rest may overrun the capacity.
    if (w.command == CMD_COMMIT && $urandom_range(0, 4) != 0)
      w.packet_length = 9'($urandom_range(0, cap_eff));
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: one predicted word per result, in order.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [8:0] want,
                             input logic [8:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result word with no command outstanding");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status",      9'(want.status),     9'(res_o.status));
        check_field("read_data",   9'(want.read_data),  9'(res_o.read_data));
        check_field("read_length", want.read_length,    res_o.read_length);
        check_field("full_flag",   9'(want.full_flag),  9'(res_o.full_flag));
        check_field("empty_flag",  9'(want.empty_flag), 9'(res_o.empty_flag));
        status_tally[want.status]++;
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || res_valid_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Release on an empty FIFO, extreme offsets/data, a full-size commit.
  task automatic test_empty_and_extremes();
    send_word(compose_word(CMD_RELEASE, 8'd0, 8'd0, 9'd0));
    send_word(compose_word(CMD_WRITE_BYTE, 8'd0, 8'hFF, 9'd0));
    send_word(compose_word(CMD_WRITE_BYTE, 8'd255, 8'h00, 9'd511 & 9'd256));
    send_word(compose_word(CMD_COMMIT, 8'hFF, 8'hFF, 9'd256));
    send_word(compose_word(CMD_READ_BYTE, 8'd255, 8'hFF, 9'd0));
    send_word(compose_word(CMD_RELEASE, 8'd0, 8'd0, 9'd0));
  endtask

  // Commit until full, then a commit and a byte write while full.
  task automatic test_fill_to_full();
    for (int i = 0; i < SLOTS; i++)
      send_word(compose_word(CMD_COMMIT, 8'd0, 8'd0,
                             9'($urandom_range(0, SLOT_BYTES))));
    send_word(compose_word(CMD_COMMIT, 8'd0, 8'd0, 9'd1));
    send_word(compose_word(CMD_WRITE_BYTE, 8'd3, 8'h5A, 9'd0));
  endtask

  // Clear keeps memory; a read while empty still returns the old byte.
  task automatic test_clear_and_stale_read();
    send_word(compose_word(CMD_CLEAR, 8'd0, 8'd0, 9'd0));
    send_word(compose_word(CMD_READ_BYTE, 8'd0, 8'd0, 9'd0));
  endtask

  task automatic test_spare_codes();
    for (int k = 0; k < CMD_SPARE_COUNT; k++)
      send_word(compose_word(CMD_SPARE_BASE + 3'(k), 8'hA5, 8'h5A, 9'd256));
  endtask

  // Capacity of one: one over is rejected, exactly at the limit passes.
  task automatic test_capacity_limit();
    drain_results();
    write_capacity(9'd1);
    send_word(compose_word(CMD_COMMIT, 8'd0, 8'd0, 9'd2));
    send_word(compose_word(CMD_COMMIT, 8'd0, 8'd0, 9'd1));
  endtask

  task automatic test_random_traffic(input logic [8:0] capacity, input int idle_pct,
                                     input int n_words);
    in_word_t w;
    drain_results();
    write_capacity(capacity);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n_words; i++) begin
      pick_random_word(w);
      send_word(w);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_extremes();
    test_fill_to_full();
    test_clear_and_stale_read();
    test_spare_codes();
    test_capacity_limit();

    // Register above SLOT_BYTES saturates; then a random mid value; then 256.
    test_random_traffic(9'd511, 19, RANDOM_WORDS);
    test_random_traffic(9'($urandom_range(2, 255)), 72, RANDOM_WORDS);
    test_random_traffic(9'd256, 0, RANDOM_WORDS);

    drain_results();
    repeat (4) @(posedge clk_i);

    $display("Ran %0d writes, %0d commits, %0d reads, %0d releases, %0d clears, %0d spare",
             cmd_tally[CMD_WRITE_BYTE], cmd_tally[CMD_COMMIT], cmd_tally[CMD_READ_BYTE],
             cmd_tally[CMD_RELEASE], cmd_tally[CMD_CLEAR],
             cmd_tally[CMD_SPARE_BASE] + cmd_tally[CMD_SPARE_BASE + 3'd1] +
             cmd_tally[CMD_SPARE_BASE + 3'd2]);
    $display("Status seen: ok %0d, full %0d, empty %0d, too long %0d; capacities %s",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_TOO_LONG], capacity_log);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/psf_pkg.sv
rtl/psf_ptr_ctrl.sv
rtl/packet_slot_fifo.sv
sim/packet_slot_fifo_tb.sv
